// File: rtl/prf_pkg.sv
// Package with the shared frame record type and constants of the page frame replacement block.
package prf_pkg;

   // Replacement policy codes
   localparam logic [1:0] POL_LRU    = 2'd0;
   localparam logic [1:0] POL_FIFO   = 2'd1;
   localparam logic [1:0] POL_SECOND = 2'd2;
   localparam logic [1:0] POL_RANDOM = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_POLICY     = 2'd0;
   localparam logic [1:0] CSR_PAGE_SHIFT = 2'd1;
   localparam logic [1:0] CSR_ADDR_SHIFT = 2'd2;

   localparam logic [15:0] LFSR_SEED = 16'hACE1;

   // One frame of the page table
   typedef struct packed {
      logic [31:0] page;
      logic        used;
      logic        valid;
      logic        ref_bit;
      logic [31:0] last_use;
      logic [31:0] load;
   } frame_type;

endpackage

// File: rtl/prf_cell.sv
// One cell of the frame ring: holds one frame record and passes it to its neighbor.
module prf_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  prf_pkg::frame_type data_in,
   output prf_pkg::frame_type data_out
);
   import prf_pkg::*;

   frame_type rec_ff;
   frame_type rec_in;

   // Take the neighbor's record on every shift.
   always_comb begin
      rec_in = rec_ff;
      if (shift) begin
         rec_in = data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff <= '0;
      end else begin
         rec_ff <= rec_in;
      end
   end

   assign data_out = rec_ff;

endmodule

// File: rtl/prf_mod.sv
// Remainder of a 16-bit value by the frame count, by reciprocal multiplication.
module prf_mod #(
   parameter int Divisor = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [15:0]                value,
   output logic                       done,
   output logic [$clog2(Divisor)-1:0] remainder
);
   localparam int IW = $clog2(Divisor);
   // Rounded-up 2^32 / Divisor; the quotient is exact for every 16-bit value.
   localparam logic [32:0] RECIP = 33'(((64'd1 << 32) + 64'(Divisor - 1)) / 64'(Divisor));
   localparam logic [IW:0] DIV = (IW+1)'(Divisor);

   logic [15:0]    val_ff, val_in;
   logic [15:0]    quot_ff, quot_in;
   logic           st1_ff, st1_in;
   logic           st2_ff, st2_in;
   logic [48:0]    prod;
   logic [16+IW:0] back_prod;

   // First stage: quotient from the reciprocal product.
   always_comb begin
      val_in = val_ff;
      if (start) begin
         val_in = value;
      end
      prod    = val_ff * RECIP;
      quot_in = 16'(prod >> 32);
      st1_in  = start;
      st2_in  = st1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_ff <= 1'b0;
         st2_ff <= 1'b0;
      end else begin
         st1_ff <= st1_in;
         st2_ff <= st2_in;
      end
      val_ff  <= val_in;
      quot_ff <= quot_in;
   end

   // Second stage: the value less quotient times divisor.
   assign back_prod = quot_ff * DIV;
   assign done      = st2_ff;
   assign remainder = IW'(val_ff - back_prod[15:0]);

endmodule

// File: rtl/page_frame_replacement.sv
// Top level of the page frame replacement block: frame ring, sequencer and result register.
//
// The result beat is presented once the lookup and update passes are through, and it is
// held while rsp_tready is low; when the random choice picks the victim, the remainder
// unit runs between the two passes. A new input beat can be accepted from the cycle after
// the result handshake. The frame records sit in a ring of cells that rotates one place
// per cycle during the lookup and update passes; a lookup pass walks all frames through
// the head cell to find the page, the first free frame and the LRU, FIFO and
// second-chance candidates, and an update pass walks them again to write the chosen
// frame and clear second-chance reference bits. The random pick steps the LFSR and
// reduces it modulo FRAME_COUNT in a two-stage reciprocal multiplication remainder unit.
// One access is handled at a time.
module page_frame_replacement #(
   parameter int FRAME_COUNT = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] address
   input  logic        req_tuser,   // [0] req_type (1 write)
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [3:0] frame_index, [35:4] page_number,
                                    // [67:36] fault_total, [71:68] zero
   output logic        rsp_tuser,   // [0] hit
   // Configuration port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_wdata
);
   import prf_pkg::*;

   localparam int IW = $clog2(FRAME_COUNT);
   localparam logic [IW-1:0] LAST = IW'(FRAME_COUNT - 1);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_LOOK = 6'b000010,
      S_PICK = 6'b000100,
      S_MOD  = 6'b001000,
      S_UPD  = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0] policy_ff;
   logic [4:0] page_shift_ff, addr_shift_ff;

   logic [31:0] key_ff, key_in;
   logic        wr_ff, wr_in;
   logic [31:0] tick_ff, tick_in;
   logic [31:0] fault_ff, fault_in;
   logic [15:0] lfsr_ff, lfsr_in;
   logic [15:0] lfsr_next;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic          found_ff, found_in;
   logic          hit_ff, hit_in;
   logic [IW-1:0] slot_ff, slot_in;
   logic [31:0]   lru_min_ff, lru_min_in;
   logic [IW-1:0] lru_idx_ff, lru_idx_in;
   logic [31:0]   fifo_min_ff, fifo_min_in;
   logic [IW-1:0] fifo_idx_ff, fifo_idx_in;
   logic          sc_found_ff, sc_found_in;
   logic [IW-1:0] sc_idx_ff, sc_idx_in;
   logic          clr_ff, clr_in;

   logic          shift;
   frame_type     ring [FRAME_COUNT];
   frame_type     head;
   frame_type     back;
   logic          mod_start, mod_done;
   logic [IW-1:0] mod_rem;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff     <= POL_LRU;
         page_shift_ff <= 5'd12;
         addr_shift_ff <= 5'd16;
      end else if (csr_we) begin
         case (csr_index)
            CSR_POLICY:     policy_ff     <= csr_wdata[1:0];
            CSR_PAGE_SHIFT: page_shift_ff <= csr_wdata;
            CSR_ADDR_SHIFT: addr_shift_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Ring of frame cells; the head is frame cnt during a pass.
   assign head = ring[0];
   genvar g;
   generate
      for (g = 0; g < FRAME_COUNT; g++) begin : g_cell
         frame_type nb;
         if (g == FRAME_COUNT - 1) begin : g_tail
            assign nb = back;
         end else begin : g_mid
            assign nb = ring[g+1];
         end
         prf_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift   (shift),
            .data_in (nb),
            .data_out(ring[g])
         );
      end
   endgenerate

   assign lfsr_next = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5], lfsr_ff[15:1]};

   prf_mod #(.Divisor(FRAME_COUNT)) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .value    (lfsr_next),
      .done     (mod_done),
      .remainder(mod_rem)
   );

   // Head record as it goes back into the ring during the update pass.
   always_comb begin
      back = head;
      if (state_ff == S_UPD) begin
         if (clr_ff && (!sc_found_ff || cnt_ff < sc_idx_ff)) begin
            back.ref_bit = 1'b0;
         end
         if (cnt_ff == slot_ff) begin
            back.last_use = tick_ff;
            if (hit_ff) begin
               if (wr_ff) begin
                  back.ref_bit = 1'b1;
               end
            end else begin
               back.page    = key_ff;
               back.used    = 1'b1;
               back.valid   = 1'b1;
               back.ref_bit = 1'b1;
               back.load    = tick_ff;
            end
         end
      end
   end

   assign shift = (state_ff == S_LOOK) || (state_ff == S_UPD);

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      key_in      = key_ff;
      wr_in       = wr_ff;
      tick_in     = tick_ff;
      fault_in    = fault_ff;
      lfsr_in     = lfsr_ff;
      cnt_in      = cnt_ff;
      found_in    = found_ff;
      hit_in      = hit_ff;
      slot_in     = slot_ff;
      lru_min_in  = lru_min_ff;
      lru_idx_in  = lru_idx_ff;
      fifo_min_in = fifo_min_ff;
      fifo_idx_in = fifo_idx_ff;
      sc_found_in = sc_found_ff;
      sc_idx_in   = sc_idx_ff;
      clr_in      = clr_ff;
      mod_start   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               key_in      = (req_tdata >> addr_shift_ff) & (32'hFFFF_FFFF >> page_shift_ff);
               wr_in       = req_tuser;
               tick_in     = tick_ff + 32'd1;
               cnt_in      = '0;
               found_in    = 1'b0;
               hit_in      = 1'b0;
               sc_found_in = 1'b0;
               clr_in      = 1'b0;
               state_in    = S_LOOK;
            end
         end
         S_LOOK: begin
            if (!found_ff && (!head.used || head.page == key_ff)) begin
               found_in = 1'b1;
               slot_in  = cnt_ff;
               hit_in   = head.used && head.valid && (head.page == key_ff);
            end
            if (cnt_ff == '0 || head.last_use < lru_min_ff) begin
               lru_min_in = head.last_use;
               lru_idx_in = cnt_ff;
            end
            if (cnt_ff == '0 || head.load < fifo_min_ff) begin
               fifo_min_in = head.load;
               fifo_idx_in = cnt_ff;
            end
            if (!sc_found_ff && !head.ref_bit) begin
               sc_found_in = 1'b1;
               sc_idx_in   = cnt_ff;
            end
            cnt_in = (cnt_ff == LAST) ? '0 : cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            state_in = S_UPD;
            if (!hit_ff) begin
               fault_in = fault_ff + 32'd1;
            end
            if (!found_ff) begin
               case (policy_ff)
                  POL_LRU:  slot_in = lru_idx_ff;
                  POL_FIFO: slot_in = fifo_idx_ff;
                  POL_SECOND: begin
                     clr_in = 1'b1;
                     if (sc_found_ff) begin
                        slot_in = sc_idx_ff;
                     end else begin
                        lfsr_in   = lfsr_next;
                        mod_start = 1'b1;
                        state_in  = S_MOD;
                     end
                  end
                  default: begin
                     lfsr_in   = lfsr_next;
                     mod_start = 1'b1;
                     state_in  = S_MOD;
                  end
               endcase
            end
         end
         S_MOD: begin
            if (mod_done) begin
               slot_in  = mod_rem;
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            cnt_in = (cnt_ff == LAST) ? '0 : cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tick_ff  <= '0;
         fault_ff <= '0;
         lfsr_ff  <= LFSR_SEED;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tick_ff  <= tick_in;
         fault_ff <= fault_in;
         lfsr_ff  <= lfsr_in;
         cnt_ff   <= cnt_in;
      end
      key_ff      <= key_in;
      wr_ff       <= wr_in;
      found_ff    <= found_in;
      hit_ff      <= hit_in;
      slot_ff     <= slot_in;
      lru_min_ff  <= lru_min_in;
      lru_idx_ff  <= lru_idx_in;
      fifo_min_ff <= fifo_min_in;
      fifo_idx_ff <= fifo_idx_in;
      sc_found_ff <= sc_found_in;
      sc_idx_ff   <= sc_idx_in;
      clr_ff      <= clr_in;
   end

   // Result beat
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tuser  = hit_ff;
   assign rsp_tdata  = {4'd0, fault_ff, key_ff, 4'(slot_ff)};

`ifndef SYNTH
   a_state_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("sequencer state is not one-hot");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while a result is pending");
   a_fault_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid)) |-> (fault_ff == $past(fault_ff)))
      else $error("fault count moved during the update pass");
`endif

endmodule
